>>> hdl/mqsb_pkg.sv
// ----------------------------------------------------------------------------
// mqsb_pkg
// Shared constants for the multi-queue shared buffer: default sizes, field
// widths, operation codes and status codes.
// ----------------------------------------------------------------------------
package mqsb_pkg;

    localparam int ENTRIES_DEF = 64;
    localparam int QUEUES_DEF  = 8;

    localparam int DATA_W   = 32;
    localparam int OP_W     = 2;
    localparam int QID_W    = 3;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

>>> hdl/multi_queue_shared_buffer.sv
// ----------------------------------------------------------------------------
// multi_queue_shared_buffer
// Several FIFO queues threaded as linked lists through one entry store, with
// a free list. Entry store and queue table are synchronous memories.
// ----------------------------------------------------------------------------
// Sequence: o_valid rises as the table-read state ends for an enqueue without
// a link update, a refused or empty item and the unused code; for an enqueue
// behind a live tail, a dequeue and a peek it rises after the link write or the
// entry read that follows the table read. busy drops as the result shows.
// Reset is synchronous: a fill count and per-queue valid bits stand in for
// clearing the memories, so no clearing pass follows. Results cannot stall.
module multi_queue_shared_buffer
    import mqsb_pkg::*;
#(
    parameter int ENTRIES = ENTRIES_DEF,
    parameter int QUEUES  = QUEUES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       start,
    output logic                       busy,
    input  logic [OP_W-1:0]            i_operation,
    input  logic [QID_W-1:0]           i_queue_id,
    input  logic signed [DATA_W-1:0]   i_data_in,
    output logic                       o_valid,
    output logic signed [DATA_W-1:0]   o_data_out,
    output logic [STATUS_W-1:0]        o_status
);

    localparam int PW  = $clog2(ENTRIES + 1);
    localparam int IW  = $clog2(ENTRIES);
    localparam int QW  = (QUEUES > 1) ? $clog2(QUEUES) : 1;
    localparam int QRW = ($clog2(QUEUES + 1) > QID_W) ? $clog2(QUEUES + 1) : QID_W;
    localparam logic [PW-1:0] NULL_PTR = PW'(ENTRIES);

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic [PW-1:0]     link;
    } t_ent;

    typedef struct packed {
        logic [PW-1:0] head;
        logic [PW-1:0] tail;
    } t_qent;

    typedef enum logic [1:0] {
        S_IDLE,
        S_TBL,
        S_ENT,
        S_LINK
    } t_state;

    function automatic logic [QW-1:0] f_qsel(input logic [QID_W-1:0] id);
        logic [QRW-1:0] v;
        v = QRW'(id);
        for (int k = 0; k < (1 << QID_W); k++) begin
            if (v >= QRW'(QUEUES)) begin
                v = v - QRW'(QUEUES);
            end
        end
        return v[QW-1:0];
    endfunction

    t_state                    r_state;
    logic [OP_W-1:0]           r_op;
    logic [QW-1:0]             r_q;
    logic signed [DATA_W-1:0]  r_word;
    logic [PW-1:0]             r_idx;
    logic [PW-1:0]             r_free_head;
    logic [PW-1:0]             r_fill;
    logic [QUEUES-1:0]         r_qvalid;
    logic                      r_valid;
    logic signed [DATA_W-1:0]  r_data;
    logic [STATUS_W-1:0]       r_status;

    t_ent                      r_ent_mem [ENTRIES];
    t_ent                      r_ent_rd;
    t_qent                     r_tbl_mem [QUEUES];
    t_qent                     r_tbl_rd;

    logic                      accept;
    logic [PW-1:0]             head_ptr;
    logic [PW-1:0]             tail_ptr;
    logic                      head_ok;
    logic                      tail_ok;
    logic                      free_ok;
    logic                      fresh;
    logic [PW-1:0]             next_free;

    logic                      ent_we_data;
    logic                      ent_we_link;
    logic [IW-1:0]             ent_wa;
    logic [PW-1:0]             ent_wd_link;
    logic [IW-1:0]             ent_ra;
    logic                      tbl_we;
    t_qent                     tbl_wd;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    assign head_ptr  = r_qvalid[r_q] ? r_tbl_rd.head : NULL_PTR;
    assign tail_ptr  = r_qvalid[r_q] ? r_tbl_rd.tail : NULL_PTR;
    assign head_ok   = (head_ptr < NULL_PTR);
    assign tail_ok   = (tail_ptr < NULL_PTR);
    assign free_ok   = (r_free_head < NULL_PTR);
    assign fresh     = (r_free_head >= r_fill);
    assign next_free = fresh ? PW'(r_free_head + PW'(1)) : r_ent_rd.link;

    assign ent_ra = (r_state == S_TBL) ? head_ptr[IW-1:0] : r_free_head[IW-1:0];

    always_comb begin
        ent_we_data = 1'b0;
        ent_we_link = 1'b0;
        ent_wa      = r_free_head[IW-1:0];
        ent_wd_link = NULL_PTR;
        tbl_we      = 1'b0;
        tbl_wd      = '{head: head_ptr, tail: r_free_head};
        case (r_state)
            S_TBL: begin
                if (r_op == OP_ENQ && free_ok) begin
                    ent_we_data = 1'b1;
                    ent_we_link = 1'b1;
                    tbl_we      = 1'b1;
                    tbl_wd      = '{head: head_ok ? head_ptr : r_free_head,
                                    tail: r_free_head};
                end
            end
            S_ENT: begin
                if (r_op == OP_DEQ) begin
                    ent_we_link = 1'b1;
                    ent_wa      = r_idx[IW-1:0];
                    ent_wd_link = r_free_head;
                    tbl_we      = 1'b1;
                    tbl_wd      = '{head: r_ent_rd.link, tail: tail_ptr};
                end
            end
            S_LINK: begin
                ent_we_link = 1'b1;
                ent_wa      = tail_ptr[IW-1:0];
                ent_wd_link = r_idx;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (ent_we_data) begin
            r_ent_mem[ent_wa].data <= r_word;
        end
        if (ent_we_link) begin
            r_ent_mem[ent_wa].link <= ent_wd_link;
        end
        if (accept || r_state == S_TBL) begin
            r_ent_rd <= r_ent_mem[ent_ra];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tbl_we) begin
            r_tbl_mem[r_q] <= tbl_wd;
        end
        if (accept) begin
            r_tbl_rd <= r_tbl_mem[f_qsel(i_queue_id)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= 1'b0;
            r_free_head <= '0;
            r_fill      <= '0;
            r_qvalid    <= '0;
        end else begin
            r_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op    <= i_operation;
                        r_q     <= f_qsel(i_queue_id);
                        r_word  <= i_data_in;
                        r_state <= S_TBL;
                    end
                end
                S_TBL: begin
                    r_data   <= '0;
                    r_status <= ST_OK;
                    r_state  <= S_IDLE;
                    r_valid  <= 1'b1;
                    case (r_op) inside
                        OP_ENQ: begin
                            if (!free_ok) begin
                                r_status <= ST_FULL;
                            end else begin
                                r_free_head     <= next_free;
                                r_qvalid[r_q]   <= 1'b1;
                                r_idx           <= r_free_head;
                                if (fresh) begin
                                    r_fill <= PW'(r_fill + PW'(1));
                                end
                                if (head_ok && tail_ok) begin
                                    r_valid <= 1'b0;
                                    r_state <= S_LINK;
                                end
                            end
                        end
                        OP_DEQ, OP_PEEK: begin
                            if (!head_ok) begin
                                r_status <= ST_EMPTY;
                            end else begin
                                r_idx   <= head_ptr;
                                r_valid <= 1'b0;
                                r_state <= S_ENT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                S_ENT: begin
                    r_data   <= r_ent_rd.data;
                    r_status <= ST_OK;
                    r_valid  <= 1'b1;
                    r_state  <= S_IDLE;
                    if (r_op == OP_DEQ) begin
                        r_free_head <= r_idx;
                    end
                end
                S_LINK: begin
                    r_data   <= '0;
                    r_status <= ST_OK;
                    r_valid  <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_valid;
    assign o_data_out = r_data;
    assign o_status   = r_status;

    a_valid_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a preceding item");

    a_full_means_no_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (r_free_head >= NULL_PTR))
        else $error("full reported with free entries left");

    a_error_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_data_out == '0))
        else $error("nonzero data on a failed item");

    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= NULL_PTR)
        else $error("fill count beyond store size");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && !o_valid))
        else $error("item accepted without going busy");

endmodule
